// File: hw/rtl/mwm_pkg.sv
package mwm_pkg;

  // Geometry and field widths
  localparam int NumWheels = 4;
  localparam int RateW     = 24;
  localparam int TimeW     = 32;
  localparam int AccelW    = 24;
  localparam int SpaceW    = 20;
  localparam int RadW      = 16;
  localparam int InvRadW   = 24;
  localparam int FracW     = 16;

  // Configuration channel
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  // Internal datapath widths
  localparam int DiffW     = SpaceW + 1;
  localparam int YawProdW  = RateW + DiffW;
  localparam int YawTermW  = 28;
  localparam int StepProdW = AccelW + TimeW;
  localparam int StepW     = StepProdW - FracW + 1;
  localparam int MeasProdW = RateW + RadW + 1;
  localparam int MeasW     = 25;
  localparam int DesW      = 29;
  localparam int ErrW      = 30;
  localparam int CmdProdW  = DesW + InvRadW + 1;
  localparam int SatInW    = 42;

  // |err| * 100 < 65536 in Q.16 holds exactly for |err| < 656
  localparam int ErrTol = 656;

  // Mixing sign pattern: bit w set means the term is subtracted for wheel w
  localparam logic [NumWheels-1:0] SideNeg = 4'b1010;
  localparam logic [NumWheels-1:0] YawNeg  = 4'b1100;

  typedef logic signed [RateW-1:0] rate_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMaxAccel,
    CfgLengthSpacing,
    CfgTrackSpacing,
    CfgWheelRadius,
    CfgInvWheelRadius,
    CfgUpdatePeriod
  } cfg_reg_e;

  typedef enum logic [3:0] {
    StIdle,
    StGate,
    StProd,
    StRnd,
    StMix,
    StErr,
    StRamp,
    StCmd,
    StOut
  } state_e;

  // Per-stage enables from the sequencer
  typedef struct packed {
    logic gate;
    logic prod;
    logic rnd;
    logic mix;
    logic err;
    logic ramp;
    logic cmd;
  } stage_t;

  localparam logic signed [SatInW-1:0] RateMaxX = SatInW'((2 ** (RateW - 1)) - 1);
  localparam logic signed [SatInW-1:0] RateMinX = -SatInW'(2 ** (RateW - 1));

  // Saturate a wide signed value to the Q7.16 field range
  function automatic rate_t sat_rate(input logic signed [SatInW-1:0] x);
    rate_t r;
    if (x > RateMaxX) begin
      r = RateMaxX[RateW-1:0];
    end else if (x < RateMinX) begin
      r = RateMinX[RateW-1:0];
    end else begin
      r = x[RateW-1:0];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/mwm_if.sv
interface mwm_item_if;
  import mwm_pkg::*;
  logic             valid;
  logic             ready;
  rate_t            target_fwd;
  rate_t            target_side;
  rate_t            target_yaw;
  rate_t            meas_rate_0;
  rate_t            meas_rate_1;
  rate_t            meas_rate_2;
  rate_t            meas_rate_3;
  logic [TimeW-1:0] time_now;

  modport source (
    output valid, target_fwd, target_side, target_yaw,
    output meas_rate_0, meas_rate_1, meas_rate_2, meas_rate_3, time_now,
    input  ready
  );
  modport sink (
    input  valid, target_fwd, target_side, target_yaw,
    input  meas_rate_0, meas_rate_1, meas_rate_2, meas_rate_3, time_now,
    output ready
  );
endinterface

interface mwm_result_if;
  import mwm_pkg::*;
  logic  valid;
  logic  ready;
  rate_t cmd_rate_0;
  rate_t cmd_rate_1;
  rate_t cmd_rate_2;
  rate_t cmd_rate_3;

  modport source (
    output valid, cmd_rate_0, cmd_rate_1, cmd_rate_2, cmd_rate_3,
    input  ready
  );
  modport sink (
    input  valid, cmd_rate_0, cmd_rate_1, cmd_rate_2, cmd_rate_3,
    output ready
  );
endinterface

interface mwm_cfg_if;
  import mwm_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/mwm_front.sv
module mwm_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  mwm_pkg::stage_t                      stage_i,
  input  logic [mwm_pkg::TimeW-1:0]            time_now_i,
  input  logic [mwm_pkg::TimeW-1:0]            update_period_i,
  input  logic [mwm_pkg::AccelW-1:0]           accel_lim_i,
  input  logic [mwm_pkg::SpaceW-1:0]           length_spacing_i,
  input  logic [mwm_pkg::SpaceW-1:0]           track_spacing_i,
  input  mwm_pkg::rate_t                       target_yaw_i,
  output logic                                 pass_o,
  output logic signed [mwm_pkg::YawTermW-1:0]  yaw_term_o,
  output logic [mwm_pkg::StepW-1:0]            step_o
);
  import mwm_pkg::*;

  logic [TimeW-1:0]            last_q;
  logic [TimeW-1:0]            dt_d;
  logic [TimeW-1:0]            dt_q;
  logic signed [DiffW-1:0]     diff;
  logic signed [YawProdW-1:0]  yaw_prod_q;
  logic [StepProdW-1:0]        step_prod_q;
  logic signed [YawProdW:0]    yaw_rnd;
  logic [StepProdW:0]          step_rnd;
  logic signed [YawTermW-1:0]  yaw_term_q;
  logic [StepW-1:0]            step_q;

  // Elapsed time since the last update, wrapping
  assign dt_d   = time_now_i - last_q;
  assign pass_o = (dt_d >= update_period_i);

  assign diff = $signed({1'b0, length_spacing_i}) - $signed({1'b0, track_spacing_i});

  // Round to nearest: yaw term halves the product (shift by 17)
  assign yaw_rnd  = (YawProdW + 1)'(yaw_prod_q) + (YawProdW + 1)'(2 ** FracW);
  assign step_rnd = {1'b0, step_prod_q} + (StepProdW + 1)'(2 ** (FracW - 1));

  // Time of last accepted update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (stage_i.gate && pass_o) begin
      last_q <= time_now_i;
    end
  end

  // Products and rounded terms shared by all wheels
  always_ff @(posedge clk_i) begin
    if (stage_i.gate) begin
      dt_q <= dt_d;
    end
    if (stage_i.prod) begin
      yaw_prod_q  <= target_yaw_i * diff;
      step_prod_q <= accel_lim_i * dt_q;
    end
    if (stage_i.rnd) begin
      yaw_term_q <= yaw_rnd[FracW+1 +: YawTermW];
      step_q     <= step_rnd[FracW +: StepW];
    end
  end

  assign yaw_term_o = yaw_term_q;
  assign step_o     = step_q;

endmodule

// File: hw/rtl/mwm_lane.sv
module mwm_lane (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mwm_pkg::stage_t                     stage_i,
  input  logic                                accel_zero_i,
  input  logic                                side_neg_i,
  input  logic                                yaw_neg_i,
  input  mwm_pkg::rate_t                      fwd_i,
  input  mwm_pkg::rate_t                      side_i,
  input  mwm_pkg::rate_t                      meas_rate_i,
  input  logic [mwm_pkg::RadW-1:0]            wheel_radius_i,
  input  logic [mwm_pkg::InvRadW-1:0]         inv_wheel_radius_i,
  input  logic signed [mwm_pkg::YawTermW-1:0] yaw_term_i,
  input  logic [mwm_pkg::StepW-1:0]           step_i,
  output mwm_pkg::rate_t                      cmd_o
);
  import mwm_pkg::*;

  logic signed [MeasProdW-1:0] meas_prod_q;
  logic signed [MeasProdW:0]   meas_rnd;
  logic signed [MeasW-1:0]     measured_q;
  logic signed [DesW-1:0]      side_x;
  logic signed [DesW-1:0]      side_term;
  logic signed [DesW-1:0]      yaw_x;
  logic signed [DesW-1:0]      yaw_part;
  logic signed [DesW-1:0]      desired_q;
  logic signed [ErrW-1:0]      err_q;
  logic                        near;
  logic                        ramp_en;
  logic signed [SatInW-1:0]    err_x;
  logic signed [SatInW-1:0]    step_s;
  logic signed [SatInW-1:0]    delta;
  rate_t                       inst_q;
  rate_t                       inst_d;
  logic signed [DesW-1:0]      speed_q;
  logic signed [CmdProdW-1:0]  cmd_prod_q;
  logic signed [CmdProdW:0]    cmd_rnd;

  assign meas_rnd = (MeasProdW + 1)'(meas_prod_q) + (MeasProdW + 1)'(2 ** (FracW - 1));

  // Mixing terms with this wheel's sign pattern
  assign side_x    = DesW'(side_i);
  assign side_term = side_neg_i ? -side_x : side_x;
  assign yaw_x     = DesW'(yaw_term_i);
  assign yaw_part  = yaw_neg_i ? -yaw_x : yaw_x;

  // Small error or no limit: pass the desired speed through
  assign near    = (err_q > -ErrTol) && (err_q < ErrTol);
  assign ramp_en = !accel_zero_i && !near;

  // Clamp error to +/- step and accumulate
  assign err_x  = SatInW'(err_q);
  assign step_s = $signed({1'b0, step_i});
  always_comb begin
    if (err_x > step_s) begin
      delta = step_s;
    end else if (err_x < -step_s) begin
      delta = -step_s;
    end else begin
      delta = err_x;
    end
    inst_d = sat_rate(SatInW'(inst_q) + delta);
  end

  // Instructed speed state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inst_q <= '0;
    end else if (stage_i.ramp && ramp_en) begin
      inst_q <= inst_d;
    end
  end

  // Lane pipeline
  always_ff @(posedge clk_i) begin
    if (stage_i.prod) begin
      meas_prod_q <= meas_rate_i * $signed({1'b0, wheel_radius_i});
    end
    if (stage_i.rnd) begin
      measured_q <= meas_rnd[FracW +: MeasW];
    end
    if (stage_i.mix) begin
      desired_q <= DesW'(fwd_i) + side_term + yaw_part;
    end
    if (stage_i.err) begin
      err_q <= ErrW'(desired_q) - ErrW'(measured_q);
    end
    if (stage_i.ramp) begin
      speed_q <= ramp_en ? DesW'(inst_d) : desired_q;
    end
    if (stage_i.cmd) begin
      cmd_prod_q <= speed_q * $signed({1'b0, inv_wheel_radius_i});
    end
  end

  // Rate command: round to Q.16 and saturate
  assign cmd_rnd = (CmdProdW + 1)'(cmd_prod_q) + (CmdProdW + 1)'(2 ** (FracW - 1));
  assign cmd_o   = sat_rate(SatInW'($signed(cmd_rnd[CmdProdW:FracW])));

endmodule

// File: hw/rtl/mecanum_wheel_mixer_slew_limit.sv
// Mecanum wheel mixer with per-wheel acceleration limit.
//
// Channels: cfg_i writes one of six registers by index (always ready;
// write only while the block is idle). item_i takes one transaction per
// update: body velocity target, four measured wheel rates and a timestamp.
// result_o carries four wheel rate commands, or nothing when less than
// update_period has elapsed since the last accepted update.
//
// Sequence: an accepted item steps through the gate, product, round, mix,
// error, ramp and command states, and its result is loaded into the output
// register from the output state; a dropped item returns to idle from gate.
// The block takes no new item until the last has left the sequencer; the
// four wheel lanes work in parallel under the same stage enables.
// The output register lets the next item be accepted while a result waits;
// a stalled receiver holds the last stage until the register frees up.
//
// Reset clears the configuration registers, the result valid flag, the
// instructed wheel speeds and the time of the last update to zero.
module mecanum_wheel_mixer_slew_limit (
  input  logic          clk_i,
  input  logic          rst_ni,
  mwm_cfg_if.sink       cfg_i,
  mwm_item_if.sink      item_i,
  mwm_result_if.source  result_o
);
  import mwm_pkg::*;

  // Configuration registers
  logic [AccelW-1:0]  accel_lim_q;
  logic [SpaceW-1:0]  length_spacing_q;
  logic [SpaceW-1:0]  track_spacing_q;
  logic [RadW-1:0]    wheel_radius_q;
  logic [InvRadW-1:0] inv_wheel_radius_q;
  logic [TimeW-1:0]   update_period_q;

  // Captured item
  rate_t              fwd_q;
  rate_t              side_q;
  rate_t              yaw_q;
  rate_t              meas_q [NumWheels];
  logic [TimeW-1:0]   time_q;

  // Sequencer
  state_e             state_q;
  state_e             state_d;
  stage_t             stage;
  logic               in_take;
  logic               out_load;
  logic               pass;

  // Result register
  logic               res_valid_q;
  rate_t              cmd_q [NumWheels];
  rate_t              lane_cmd [NumWheels];

  logic signed [YawTermW-1:0] yaw_term;
  logic [StepW-1:0]           step;

  // Configuration writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_lim_q        <= '0;
      length_spacing_q   <= '0;
      track_spacing_q    <= '0;
      wheel_radius_q     <= '0;
      inv_wheel_radius_q <= '0;
      update_period_q    <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        CfgMaxAccel:       accel_lim_q        <= cfg_i.data[AccelW-1:0];
        CfgLengthSpacing:  length_spacing_q   <= cfg_i.data[SpaceW-1:0];
        CfgTrackSpacing:   track_spacing_q    <= cfg_i.data[SpaceW-1:0];
        CfgWheelRadius:    wheel_radius_q     <= cfg_i.data[RadW-1:0];
        CfgInvWheelRadius: inv_wheel_radius_q <= cfg_i.data[InvRadW-1:0];
        CfgUpdatePeriod:   update_period_q    <= cfg_i.data[TimeW-1:0];
        default: ;
      endcase
    end
  end

  // Input capture
  assign item_i.ready = (state_q == StIdle);
  assign in_take      = item_i.valid && item_i.ready;

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      fwd_q     <= item_i.target_fwd;
      side_q    <= item_i.target_side;
      yaw_q     <= item_i.target_yaw;
      meas_q[0] <= item_i.meas_rate_0;
      meas_q[1] <= item_i.meas_rate_1;
      meas_q[2] <= item_i.meas_rate_2;
      meas_q[3] <= item_i.meas_rate_3;
      time_q    <= item_i.time_now;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_take) state_d = StGate;
      StGate:  state_d = pass ? StProd : StIdle;
      StProd:  state_d = StRnd;
      StRnd:   state_d = StMix;
      StMix:   state_d = StErr;
      StErr:   state_d = StRamp;
      StRamp:  state_d = StCmd;
      StCmd:   state_d = StOut;
      StOut:   if (out_load) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Stage enables
  always_comb begin
    stage    = '0;
    out_load = 1'b0;
    unique case (state_q)
      StGate:  stage.gate = 1'b1;
      StProd:  stage.prod = 1'b1;
      StRnd:   stage.rnd  = 1'b1;
      StMix:   stage.mix  = 1'b1;
      StErr:   stage.err  = 1'b1;
      StRamp:  stage.ramp = 1'b1;
      StCmd:   stage.cmd  = 1'b1;
      StOut:   out_load   = !res_valid_q || result_o.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Shared elapsed-time gate, yaw term and ramp step
  mwm_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .stage_i          (stage),
    .time_now_i       (time_q),
    .update_period_i  (update_period_q),
    .accel_lim_i      (accel_lim_q),
    .length_spacing_i (length_spacing_q),
    .track_spacing_i  (track_spacing_q),
    .target_yaw_i     (yaw_q),
    .pass_o           (pass),
    .yaw_term_o       (yaw_term),
    .step_o           (step)
  );

  // One lane per wheel
  for (genvar g = 0; g < NumWheels; g++) begin : g_lane
    mwm_lane u_lane (
      .clk_i              (clk_i),
      .rst_ni             (rst_ni),
      .stage_i            (stage),
      .accel_zero_i       (accel_lim_q == '0),
      .side_neg_i         (SideNeg[g]),
      .yaw_neg_i          (YawNeg[g]),
      .fwd_i              (fwd_q),
      .side_i             (side_q),
      .meas_rate_i        (meas_q[g]),
      .wheel_radius_i     (wheel_radius_q),
      .inv_wheel_radius_i (inv_wheel_radius_q),
      .yaw_term_i         (yaw_term),
      .step_i             (step),
      .cmd_o              (lane_cmd[g])
    );
  end

  // Merge lane commands into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (out_load) begin
      res_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      cmd_q <= lane_cmd;
    end
  end

  assign result_o.valid      = res_valid_q;
  assign result_o.cmd_rate_0 = cmd_q[0];
  assign result_o.cmd_rate_1 = cmd_q[1];
  assign result_o.cmd_rate_2 = cmd_q[2];
  assign result_o.cmd_rate_3 = cmd_q[3];

endmodule
